[src/brake_decel_detector_macros.svh]
// Assertion macros used by the brake deceleration detector top level.
`ifndef BRAKE_DECEL_DETECTOR_MACROS_SVH
`define BRAKE_DECEL_DETECTOR_MACROS_SVH

// Combinational check, evaluated at every rising clock edge outside reset.
`define BDD_ASSERT_COMB(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Implication check with same-cycle consequent.
`define BDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

[src/bdd_pkg.sv]
// Shared types and constants of the brake deceleration detector.
package bdd_pkg;

  // Samples per detection window.
  localparam int unsigned WINDOW = 10;
  localparam int unsigned POS_W  = $clog2(WINDOW);
  // Window sum and window limit width, with headroom for the sign.
  localparam int unsigned SUM_W  = 17 + $clog2(WINDOW);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned TALLY_W  = 6;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned LIMIT_W  = 15;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  typedef enum logic [1:0] {
    LIGHT_OFF    = 2'd0,
    LIGHT_NORMAL = 2'd1,
    LIGHT_BRAKE  = 2'd2
  } light_cmd_e;

  typedef enum logic [2:0] {
    CFG_ALPHA      = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_MIN_PAIRS  = 3'd2,
    CFG_HOLD       = 3'd3,
    CFG_TAILLIGHT  = 3'd4,
    CFG_VALID_LIM  = 3'd5
  } cfg_reg_e;

  // Settings the window stage needs from the register file.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] threshold;
    logic [TALLY_W-1:0]         min_pairs;
  } win_cfg_t;

endpackage

[src/bdd_filter.sv]
// First-order IIR low-pass with a Q.8 state register.
module bdd_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 upd_i,
  input  logic signed [bdd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [bdd_pkg::ALPHA_W-1:0]          alpha_i,
  output logic signed [bdd_pkg::SAMPLE_W-1:0]  fv_new_o,
  output logic signed [bdd_pkg::SAMPLE_W-1:0]  fv_cur_o
);

  logic signed [bdd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [bdd_pkg::ALPHA_W-1:0]      a_sat;
  logic [bdd_pkg::ALPHA_W-1:0]      a_inv;
  logic signed [25:0]               prod_new;
  logic signed [33:0]               prod_old;
  logic signed [34:0]               mix;
  logic signed [24:0]               acc_rnd;
  logic signed [24:0]               cur_rnd;

  assign a_sat = (alpha_i > bdd_pkg::ALPHA_ONE) ? bdd_pkg::ALPHA_ONE : alpha_i;
  assign a_inv = bdd_pkg::ALPHA_ONE - a_sat;

  assign prod_new = sample_i * $signed({1'b0, a_sat});
  assign prod_old = acc_q * $signed({1'b0, a_inv});

  // Weighted sum in Q.16, rounded half up back to Q.8.
  assign mix   = $signed({prod_new[25], prod_new, 8'd0}) + $signed({prod_old[33], prod_old})
               + 35'sd128;
  assign acc_d = mix[31:8];

  assign acc_rnd  = $signed({acc_d[23], acc_d}) + 25'sd128;
  assign cur_rnd  = $signed({acc_q[23], acc_q}) + 25'sd128;
  assign fv_new_o = acc_rnd[23:8];
  assign fv_cur_o = cur_rnd[23:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (upd_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

[src/bdd_window.sv]
// Window statistics: falling-pair tally, running sum and end-of-window test.
module bdd_window (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 upd_i,
  input  logic signed [bdd_pkg::SAMPLE_W-1:0]  fv_i,
  input  bdd_pkg::win_cfg_t                    cfg_i,
  output logic                                 detected_o
);

  logic signed [bdd_pkg::SAMPLE_W-1:0] prev_q;
  logic signed [bdd_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [bdd_pkg::TALLY_W-1:0]         tally_q, tally_d;
  logic [bdd_pkg::POS_W-1:0]           pos_q;
  logic                                last;
  logic                                falling;
  logic signed [bdd_pkg::SUM_W-1:0]    limit;

  assign last    = (pos_q == bdd_pkg::POS_W'(bdd_pkg::WINDOW - 1));
  assign falling = (pos_q != '0) && (fv_i < prev_q);
  assign tally_d = tally_q + bdd_pkg::TALLY_W'(falling);
  assign sum_d   = sum_q + bdd_pkg::SUM_W'(fv_i);
  assign limit   = $signed(bdd_pkg::SUM_W'(bdd_pkg::WINDOW))
                 * bdd_pkg::SUM_W'(cfg_i.threshold);

  assign detected_o = last && (tally_d >= cfg_i.min_pairs) && (sum_d <= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      sum_q   <= '0;
      tally_q <= '0;
      pos_q   <= '0;
    end else if (upd_i) begin
      prev_q <= fv_i;
      if (last) begin
        sum_q   <= '0;
        tally_q <= '0;
        pos_q   <= '0;
      end else begin
        sum_q   <= sum_d;
        tally_q <= tally_d;
        pos_q   <= pos_q + 1'b1;
      end
    end
  end

endmodule

[src/brake_decel_detector.sv]
// Top level of the brake deceleration detector.
//
// Usage: acceleration samples enter on the sample channel (sample_valid_i,
// sample_ready_o, sample_ax_i). Every sample yields exactly one result word
// on the result channel (result_valid_o, result_ready_i and the four result
// fields). Settings are written through the configuration channel, which is
// always ready; a write should only be issued while the block is idle.
// An accepted sample sits in the input register while the filter and window
// update run in one pass, and the result is captured in the output register
// when the input register advances. Throughput is one sample per cycle while
// the receiver keeps taking results. Reset clears the filter, the window
// counters and the brake hold and loads the default settings. When the
// receiver stalls, the result waits in the output register while one more
// sample can still be taken into the input register; then sample_ready_o
// drops until the result is taken.
module brake_decel_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [bdd_pkg::SAMPLE_W-1:0]  sample_ax_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [1:0]                           light_cmd_o,
  output logic                                 brake_detected_o,
  output logic                                 sample_rejected_o,
  output logic signed [bdd_pkg::SAMPLE_W-1:0]  filtered_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);

  `include "brake_decel_detector_macros.svh"

  // Configuration registers.
  logic [bdd_pkg::ALPHA_W-1:0]         alpha_q;
  logic signed [bdd_pkg::SAMPLE_W-1:0] threshold_q;
  logic [bdd_pkg::TALLY_W-1:0]         min_pairs_q;
  logic [bdd_pkg::HOLD_W-1:0]          hold_samples_q;
  logic                                taillight_q;
  logic [bdd_pkg::LIMIT_W-1:0]         valid_limit_q;

  // Input register and pipeline control.
  logic                                stg_valid_q;
  logic signed [bdd_pkg::SAMPLE_W-1:0] stg_sample_q;
  logic                                advance;
  logic                                rejected;
  logic                                upd;
  logic signed [bdd_pkg::SAMPLE_W:0]   x_ext;
  logic [bdd_pkg::SAMPLE_W:0]          mag;

  // Datapath results.
  logic signed [bdd_pkg::SAMPLE_W-1:0] fv_new;
  logic signed [bdd_pkg::SAMPLE_W-1:0] fv_cur;
  logic                                detected;
  bdd_pkg::win_cfg_t                   win_cfg;
  logic [bdd_pkg::HOLD_W-1:0]          hold_left_q, hold_left_d;
  bdd_pkg::light_cmd_e                 light_d;

  // Output register.
  logic                                res_valid_q;
  bdd_pkg::light_cmd_e                 res_light_q;
  logic                                res_det_q;
  logic                                res_rej_q;
  logic signed [bdd_pkg::SAMPLE_W-1:0] res_fv_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q        <= 9'd51;
      threshold_q    <= -16'sd154;
      min_pairs_q    <= 6'd4;
      hold_samples_q <= 16'd400;
      taillight_q    <= 1'b1;
      valid_limit_q  <= 15'd16384;
    end else if (cfg_valid_i) begin
      unique case (bdd_pkg::cfg_reg_e'(cfg_index_i))
        bdd_pkg::CFG_ALPHA:     alpha_q        <= cfg_data_i[bdd_pkg::ALPHA_W-1:0];
        bdd_pkg::CFG_THRESHOLD: threshold_q    <= $signed(cfg_data_i);
        bdd_pkg::CFG_MIN_PAIRS: min_pairs_q    <= cfg_data_i[bdd_pkg::TALLY_W-1:0];
        bdd_pkg::CFG_HOLD:      hold_samples_q <= cfg_data_i;
        bdd_pkg::CFG_TAILLIGHT: taillight_q    <= cfg_data_i[0];
        bdd_pkg::CFG_VALID_LIM: valid_limit_q  <= cfg_data_i[bdd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the output register is free or
  // its word is being taken in this cycle.
  assign advance        = stg_valid_q && (!res_valid_q || result_ready_i);
  assign sample_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      stg_valid_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_valid_i && sample_ready_o) begin
      stg_sample_q <= sample_ax_i;
    end
  end

  // Magnitude test; the most negative code has magnitude 32768 and is
  // therefore always above any limit.
  assign x_ext    = {stg_sample_q[bdd_pkg::SAMPLE_W-1], stg_sample_q};
  assign mag      = x_ext[bdd_pkg::SAMPLE_W] ? $unsigned(-x_ext) : $unsigned(x_ext);
  assign rejected = mag > {2'b00, valid_limit_q};
  assign upd      = advance && !rejected;

  assign win_cfg.threshold = threshold_q;
  assign win_cfg.min_pairs = min_pairs_q;

  bdd_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .sample_i (stg_sample_q),
    .alpha_i  (alpha_q),
    .fv_new_o (fv_new),
    .fv_cur_o (fv_cur)
  );

  bdd_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .fv_i       (fv_new),
    .cfg_i      (win_cfg),
    .detected_o (detected)
  );

  // Brake hold: a detection reloads it, otherwise it counts down to zero.
  // A rejected sample leaves it alone and reports the current command.
  always_comb begin
    hold_left_d = hold_left_q;
    if (upd) begin
      if (detected) begin
        hold_left_d = hold_samples_q;
      end else if (hold_left_q != '0) begin
        hold_left_d = hold_left_q - 1'b1;
      end
    end
  end

  always_comb begin
    if (hold_left_d != '0) begin
      light_d = bdd_pkg::LIGHT_BRAKE;
    end else if (taillight_q) begin
      light_d = bdd_pkg::LIGHT_NORMAL;
    end else begin
      light_d = bdd_pkg::LIGHT_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      hold_left_q <= hold_left_d;
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_light_q <= light_d;
      res_det_q   <= upd && detected;
      res_rej_q   <= rejected;
      res_fv_q    <= upd ? fv_new : fv_cur;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign light_cmd_o       = res_light_q;
  assign brake_detected_o  = res_det_q;
  assign sample_rejected_o = res_rej_q;
  assign filtered_value_o  = res_fv_q;

  // The hold counter always belongs to the word in the output register.
  `BDD_ASSERT_IMPL(a_light_tracks_hold, clk_i, rst_ni, res_valid_q,
                   (res_light_q == bdd_pkg::LIGHT_BRAKE) == (hold_left_q != '0))
  // A rejected sample can never close a window.
  `BDD_ASSERT_IMPL(a_reject_no_detect, clk_i, rst_ni, res_valid_q,
                   !(res_rej_q && res_det_q))
  // Back-pressure only appears with a word waiting in the input register.
  `BDD_ASSERT_IMPL(a_stall_needs_item, clk_i, rst_ni, !sample_ready_o,
                   stg_valid_q && res_valid_q && !result_ready_i)

endmodule
